// File: hw/rtl/sbps_pkg.sv
// Shared codes and the pair ordering function of the sorted bucket pair set.
`default_nettype none

package sbps_pkg;

    // Request codes carried by the action field.
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_TEST   = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Register index of key_base in the configuration space.
    localparam logic REG_KEY_BASE = 1'b0;

    // Flipping both sign bits makes signed lexicographic order plain unsigned order.
    function automatic logic [31:0] order_key(input logic [31:0] packed_pair);
        order_key = packed_pair ^ 32'h8000_8000;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sorted_bucket_pair_set.sv
// Top level of the sorted bucket pair set: count and pair memories with a search and shift sequencer.
`default_nettype none

// Answers: a key outside the table is answered in the cycle after start, an insert into a full bucket
//   once S_COUNT has read its count; otherwise a test runs p <= ceil(log2(count+1)) search probes,
//   and an insert then shifts the count-pos entries above its position and stores the pair.
// One word at a time; each probe runs S_PROBE and S_CMP, each shifted entry S_SHRD and S_SHWR.
// Reset: after i_rst_n is released a clearing pass zeroes the bucket counts, one per cycle,
//   with busy high; the pair memory is not cleared. Results cannot be stalled.
module sorted_bucket_pair_set #(
    parameter int NUM_KEYS        = 64,
    parameter int BUCKET_CAPACITY = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Command channel.
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_action,
    input  wire logic signed [15:0] i_key,
    input  wire logic signed [15:0] i_first_value,
    input  wire logic signed [15:0] i_second_value,
    // Result channel.
    output logic                    o_done,
    output logic                    o_found,
    output logic [1:0]              o_status,
    // Configuration port.
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import sbps_pkg::*;

    localparam int KW     = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int CW     = $clog2(BUCKET_CAPACITY + 1);
    localparam int DEPTH  = NUM_KEYS * BUCKET_CAPACITY;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_COUNT = 7'b0000100,
        S_PROBE = 7'b0001000,
        S_CMP   = 7'b0010000,
        S_SHRD  = 7'b0100000,
        S_SHWR  = 7'b1000000
    } t_state;

    // Control and item registers.
    t_state                r_state, n_state;
    logic [KW-1:0]         r_clr, n_clr;
    logic signed [15:0]    r_key_base, n_key_base;
    logic                  r_action, n_action;
    logic [31:0]           r_packed, n_packed;
    logic [KW-1:0]         r_idx, n_idx;
    logic [AW-1:0]         r_base, n_base;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [CW-1:0]         r_lo, n_lo;
    logic [CW-1:0]         r_hi, n_hi;
    logic [CW-1:0]         r_mid, n_mid;
    logic [CW-1:0]         r_j, n_j;
    logic                  r_hit, n_hit;
    logic                  r_done, n_done;
    logic                  r_found, n_found;
    logic [1:0]            r_status, n_status;

    // Memories and their ports.
    logic [CW-1:0]         cnt_mem [NUM_KEYS];
    logic [31:0]           pair_mem [DEPTH];
    logic [CW-1:0]         r_cnt_rdata;
    logic [31:0]           r_pair_rdata;
    logic [KW-1:0]         w_cnt_raddr;
    logic                  w_cnt_we;
    logic [KW-1:0]         w_cnt_waddr;
    logic [CW-1:0]         w_cnt_wdata;
    logic [AW-1:0]         w_pair_raddr;
    logic                  w_pair_we;
    logic [AW-1:0]         w_pair_waddr;
    logic [31:0]           w_pair_wdata;

    // Bucket index arithmetic.
    logic signed [16:0]    w_diff;
    logic                  w_in_range;
    logic [KW-1:0]         w_idx;
    logic [CW-1:0]         w_mid;
    logic                  w_cfg_wr;

    assign w_diff     = {i_key[15], i_key} - {r_key_base[15], r_key_base};
    assign w_in_range = !w_diff[16] && ($unsigned(w_diff) < 17'(NUM_KEYS));
    assign w_idx      = w_diff[KW-1:0];
    assign w_mid      = r_lo + ((r_hi - r_lo) >> 1);
    assign w_cfg_wr   = psel && penable && pwrite && pready;

    // Configuration port.
    assign pready = 1'b1;
    always_comb begin
        if (paddr[2] == REG_KEY_BASE) begin
            prdata = {{16{r_key_base[15]}}, r_key_base};
        end else begin
            prdata = 32'd0;
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_found  = r_found;
    assign o_status = r_status;

    // Sequencer: clear, count lookup, binary search, shift and store.
    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_key_base   = r_key_base;
        n_action     = r_action;
        n_packed     = r_packed;
        n_idx        = r_idx;
        n_base       = r_base;
        n_cnt        = r_cnt;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_j          = r_j;
        n_hit        = r_hit;
        n_done       = 1'b0;
        n_found      = r_found;
        n_status     = r_status;
        w_cnt_raddr  = w_idx;
        w_cnt_we     = 1'b0;
        w_cnt_waddr  = r_idx;
        w_cnt_wdata  = r_cnt + CW'(1);
        w_pair_raddr = r_base + AW'(w_mid);
        w_pair_we    = 1'b0;
        w_pair_waddr = r_base + AW'(r_j);
        w_pair_wdata = r_pair_rdata;

        if (w_cfg_wr && paddr[2] == REG_KEY_BASE) begin
            n_key_base = pwdata[15:0];
        end

        case (r_state)
            S_CLEAR: begin
                w_cnt_we    = 1'b1;
                w_cnt_waddr = r_clr;
                w_cnt_wdata = '0;
                n_clr       = r_clr + KW'(1);
                if (r_clr == KW'(NUM_KEYS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_action = i_action;
                    n_packed = {i_first_value, i_second_value};
                    n_idx    = w_idx;
                    n_base   = AW'(w_idx * BUCKET_CAPACITY);
                    if (w_in_range) begin
                        n_state = S_COUNT;
                    end else begin
                        n_done   = 1'b1;
                        n_found  = 1'b0;
                        n_status = ST_RANGE;
                    end
                end
            end
            S_COUNT: begin
                n_cnt = r_cnt_rdata;
                n_lo  = '0;
                n_hi  = r_cnt_rdata;
                n_hit = 1'b0;
                if (r_action == ACT_INSERT && r_cnt_rdata >= CW'(BUCKET_CAPACITY)) begin
                    n_done   = 1'b1;
                    n_found  = 1'b0;
                    n_status = ST_FULL;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (r_lo < r_hi) begin
                    n_mid   = w_mid;
                    n_state = S_CMP;
                end else if (r_action == ACT_TEST) begin
                    n_done   = 1'b1;
                    n_found  = r_hit;
                    n_status = ST_OK;
                    n_state  = S_IDLE;
                end else begin
                    n_j     = r_cnt;
                    n_state = S_SHRD;
                end
            end
            S_CMP: begin
                // The last probe not below the target sits at the final position.
                if (order_key(r_pair_rdata) < order_key(r_packed)) begin
                    n_lo = r_mid + CW'(1);
                end else begin
                    n_hi  = r_mid;
                    n_hit = (r_pair_rdata == r_packed);
                end
                n_state = S_PROBE;
            end
            S_SHRD: begin
                w_pair_raddr = r_base + AW'(r_j - CW'(1));
                if (r_j == r_lo) begin
                    w_pair_we    = 1'b1;
                    w_pair_wdata = r_packed;
                    w_cnt_we     = 1'b1;
                    n_done       = 1'b1;
                    n_found      = 1'b0;
                    n_status     = ST_OK;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_SHWR;
                end
            end
            S_SHWR: begin
                // Entry j-1 has been read; move it up to j.
                w_pair_we = 1'b1;
                n_j       = r_j - CW'(1);
                n_state   = S_SHRD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_key_base <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr      <= n_clr;
            r_key_base <= n_key_base;
            r_done     <= n_done;
        end
    end

    // Item and result payload registers.
    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_packed <= n_packed;
        r_idx    <= n_idx;
        r_base   <= n_base;
        r_cnt    <= n_cnt;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_j      <= n_j;
        r_hit    <= n_hit;
        r_found  <= n_found;
        r_status <= n_status;
    end

    // Bucket count memory.
    always_ff @(posedge i_clk) begin
        if (w_cnt_we) begin
            cnt_mem[w_cnt_waddr] <= w_cnt_wdata;
        end
        r_cnt_rdata <= cnt_mem[w_cnt_raddr];
    end

    // Pair memory.
    always_ff @(posedge i_clk) begin
        if (w_pair_we) begin
            pair_mem[w_pair_waddr] <= w_pair_wdata;
        end
        r_pair_rdata <= pair_mem[w_pair_raddr];
    end

`ifndef SYNTH
    // A result word is only shown once the sequencer has returned to idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == S_IDLE)
        else $error("result strobe outside idle");

    // A pair can only be reported found with an ok status.
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_found) |-> o_status == ST_OK)
        else $error("found with bad status");

    // The search window never inverts.
    a_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE || r_state == S_CMP) |-> r_lo <= r_hi)
        else $error("search window inverted");

    // A stored bucket count never exceeds the capacity.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_COUNT |-> r_cnt_rdata <= CW'(BUCKET_CAPACITY))
        else $error("bucket count above capacity");

    // An accepted word either answers at once or keeps the block busy.
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted word lost");
`endif

endmodule

`default_nettype wire
